>>> sv/pcrx_pkg.sv
package pcrx_pkg;

    // operation codes
    localparam logic OP_EXTEND  = 1'b0;
    localparam logic OP_COMPARE = 1'b1;

    // status codes of a result word
    localparam logic [1:0] ST_EXTENDED = 2'd0;
    localparam logic [1:0] ST_SKIPPED  = 2'd1;
    localparam logic [1:0] ST_IGNORED  = 2'd2;
    localparam logic [1:0] ST_COMPARED = 2'd3;

    localparam logic [31:0] NO_ACTION_EVENT = 32'h0000_0003;
    localparam logic [15:0] DIGEST_BYTES    = 16'd32;
    localparam int          MASK_BITS       = 8;
    localparam int          ROUNDS          = 64;

    // APB byte address width, and the value of address bit 2 that selects the exempt register
    localparam int          PADDR_W    = 3;
    localparam logic        REG_EXEMPT = 1'b0;

    typedef logic [31:0]  sha_word_t;
    typedef logic [255:0] pcr_value_t;

    localparam sha_word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam sha_word_t PAD_FIRST = 32'h8000_0000;
    localparam sha_word_t PAD_LAST  = 32'h0000_0200;

    function automatic sha_word_t sha_k(input logic [5:0] t);
        sha_word_t k;
        case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic sha_word_t rotr(input sha_word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic sha_word_t big_sigma0(input sha_word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic sha_word_t big_sigma1(input sha_word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic sha_word_t small_sigma0(input sha_word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic sha_word_t small_sigma1(input sha_word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> sv/pcrx_if.sv
interface pcrx_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [4:0]  pcr_index;
    logic [31:0] event_type;
    logic [15:0] digest_len;
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;

    modport source (output valid, op, pcr_index, event_type, digest_len,
                    word0, word1, word2, word3, input ready);
    modport sink (input valid, op, pcr_index, event_type, digest_len,
                  word0, word1, word2, word3, output ready);
endinterface

interface pcrx_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        mismatch;
    logic        verdict;
    logic [63:0] pcr_out0;
    logic [63:0] pcr_out1;
    logic [63:0] pcr_out2;
    logic [63:0] pcr_out3;

    modport source (output valid, status, mismatch, verdict,
                    pcr_out0, pcr_out1, pcr_out2, pcr_out3, input ready);
    modport sink (input valid, status, mismatch, verdict,
                  pcr_out0, pcr_out1, pcr_out2, pcr_out3, output ready);
endinterface

>>> sv/pcr_extend_and_compare.sv
// channel | dir | words carried
// req     | in  | op, pcr_index, event_type, digest_len, word0..word3
// rsp     | out | status, mismatch, verdict, pcr_out0..pcr_out3
// apb     | in  | exempt_mask write/read at byte address 0
//
// One word at a time. Extend runs from accept to result through read, eval,
// two 64-round SHA-256 compressions on one round unit, two add-backs, load.
// Skip, compare and ignored index run through read, eval, load. A new word is
// taken once the previous one sits in the output register. Reset clears the
// bank through per-entry valid bits at once; no clearing pass. A stalled rsp
// holds the final load, and no next word is accepted meanwhile.
module pcr_extend_and_compare
    import pcrx_pkg::*;
#(
    parameter int NUM_PCRS = 8
)(
    input  logic               clk,
    input  logic               rst_n,
    pcrx_req_if.sink           req,
    pcrx_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = (NUM_PCRS > 1) ? $clog2(NUM_PCRS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_RND1 = 3'd2;
    localparam logic [2:0] S_ADD1 = 3'd3;
    localparam logic [2:0] S_RND2 = 3'd4;
    localparam logic [2:0] S_ADD2 = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [5:0]          cnt_reg;
    logic [NUM_PCRS-1:0] valid_reg;
    logic                verdict_reg;
    logic [MASK_BITS-1:0] exempt_reg;
    logic                out_valid_reg;

    // captured word
    logic                op_reg;
    logic [4:0]          idx_reg;
    logic [31:0]         event_reg;
    logic [15:0]         len_reg;
    pcr_value_t          words_reg;

    pcr_value_t          bank_mem [NUM_PCRS];
    pcr_value_t          rd_data_reg;

    sha_word_t           v_reg [8];
    sha_word_t           h_reg [8];
    sha_word_t           w_reg [16];

    logic [1:0]          res_status_reg;
    logic                res_mism_reg;
    pcr_value_t          res_pcr_reg;

    logic [1:0]          out_status_reg;
    logic                out_mism_reg;
    logic                out_verdict_reg;
    pcr_value_t          out_pcr_reg;

    logic                in_fire;
    logic                out_free;
    logic                in_range;
    logic [IDX_W-1:0]    idx_lo;
    logic [IDX_W-1:0]    req_idx_lo;
    pcr_value_t          old_value;
    pcr_value_t          digest;
    logic                mism;
    logic                exempt;
    logic                cfg_write;
    sha_word_t           t1;
    sha_word_t           t2;
    sha_word_t           w_new;
    pcr_value_t          final_value;

    assign in_fire    = req.valid && req.ready;
    assign req.ready  = (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign idx_lo     = idx_reg[IDX_W-1:0];
    assign req_idx_lo = req.pcr_index[IDX_W-1:0];
    assign in_range   = {1'b0, idx_reg} < 6'(NUM_PCRS);
    assign old_value  = valid_reg[idx_lo] ? rd_data_reg : '0;
    assign cfg_write  = psel && penable && pwrite && pready;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXEMPT) ? {24'd0, exempt_reg} : 32'd0;

    // cut the digest to min(len, 32) bytes
    always_comb
    begin
        for (int j = 0; j < 32; j++)
        begin
            digest[255-8*j -: 8] = (len_reg > 16'(j)) ? words_reg[255-8*j -: 8] : 8'd0;
        end
    end

    assign mism   = (len_reg != DIGEST_BYTES) || (words_reg != old_value);
    assign exempt = (idx_reg < 5'd8) && exempt_reg[idx_reg[2:0]];

    // one SHA-256 round, the next schedule word and the final add-back
    always_comb
    begin
        t1 = v_reg[7] + big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha_k(cnt_reg) + w_reg[0];
        t2 = big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);
        for (int i = 0; i < 8; i++)
        begin
            final_value[255-32*i -: 32] = h_reg[i] + v_reg[i];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_fire) state_next = S_EVAL;
            S_EVAL:
                if (in_range && op_reg == OP_EXTEND && event_reg != NO_ACTION_EVENT)
                    state_next = S_RND1;
                else
                    state_next = S_DONE;
            S_RND1:
                if (cnt_reg == 6'(ROUNDS - 1)) state_next = S_ADD1;
            S_ADD1:
                state_next = S_RND2;
            S_RND2:
                if (cnt_reg == 6'(ROUNDS - 1)) state_next = S_ADD2;
            S_ADD2:
                state_next = S_DONE;
            S_DONE:
                if (out_free) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            verdict_reg   <= 1'b0;
            exempt_reg    <= MASK_BITS'(65);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && paddr[2] == REG_EXEMPT)
                exempt_reg <= pwdata[MASK_BITS-1:0];
            if (state_reg == S_RND1 || state_reg == S_RND2)
                cnt_reg <= cnt_reg + 6'd1;
            else
                cnt_reg <= '0;
            if (state_reg == S_EVAL && in_range && op_reg == OP_COMPARE && mism && !exempt)
                verdict_reg <= 1'b1;
            if (state_reg == S_ADD2)
                valid_reg[idx_lo] <= 1'b1;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // register bank: read on accept, write back after the second compression
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD2)
            bank_mem[idx_lo] <= final_value;
        if (in_fire)
            rd_data_reg <= bank_mem[req_idx_lo];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= req.op;
            idx_reg   <= req.pcr_index;
            event_reg <= req.event_type;
            len_reg   <= req.digest_len;
            words_reg <= {req.word0, req.word1, req.word2, req.word3};
        end
        case (state_reg)
            S_EVAL:
            begin
                if (!in_range)
                begin
                    res_status_reg <= ST_IGNORED;
                    res_mism_reg   <= 1'b0;
                    res_pcr_reg    <= '0;
                end
                else if (op_reg == OP_COMPARE)
                begin
                    res_status_reg <= ST_COMPARED;
                    res_mism_reg   <= mism;
                    res_pcr_reg    <= old_value;
                end
                else
                begin
                    res_status_reg <= (event_reg == NO_ACTION_EVENT) ? ST_SKIPPED : ST_EXTENDED;
                    res_mism_reg   <= 1'b0;
                    res_pcr_reg    <= old_value;
                end
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= INIT_H[i];
                    v_reg[i] <= INIT_H[i];
                    w_reg[i]     <= old_value[255-32*i -: 32];
                    w_reg[8 + i] <= digest[255-32*i -: 32];
                end
            end
            S_RND1, S_RND2:
            begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= w_new;
            end
            S_ADD1:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                    v_reg[i] <= h_reg[i] + v_reg[i];
                end
                for (int i = 1; i < 15; i++)
                begin
                    w_reg[i] <= '0;
                end
                w_reg[0]  <= PAD_FIRST;
                w_reg[15] <= PAD_LAST;
            end
            S_ADD2:
                res_pcr_reg <= final_value;
            S_DONE:
                if (out_free)
                begin
                    out_status_reg  <= res_status_reg;
                    out_mism_reg    <= res_mism_reg;
                    out_verdict_reg <= verdict_reg;
                    out_pcr_reg     <= res_pcr_reg;
                end
            default:
            begin
            end
        endcase
    end

    // drive the result word
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.mismatch = out_mism_reg;
    assign rsp.verdict  = out_verdict_reg;
    assign rsp.pcr_out0 = out_pcr_reg[255:192];
    assign rsp.pcr_out1 = out_pcr_reg[191:128];
    assign rsp.pcr_out2 = out_pcr_reg[127:64];
    assign rsp.pcr_out3 = out_pcr_reg[63:0];

`ifndef SYNTHESIS
    // verdict is sticky
    assert property (@(posedge clk) disable iff (!rst_n) verdict_reg |=> verdict_reg)
        else $error("verdict flag cleared");

    // a mismatch is only reported by a compare
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_mism_reg) |-> (out_status_reg == ST_COMPARED))
        else $error("mismatch on a non-compare result");

    // an ignored index reports a zero register
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_IGNORED) |-> (out_pcr_reg == '0))
        else $error("ignored index with non-zero value");

    // the second compression starts from round zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD1) |=> (state_reg == S_RND2 && cnt_reg == 6'd0))
        else $error("second compression misaligned");
`endif

endmodule
